### rtl/lrd_pkg.sv
// lrd_pkg: shared constants and types for the lehmer range draw block
// no dependencies; used by the interfaces and every rtl module
package lrd_pkg;

	localparam int unsigned GEN_W   = 31;
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned DISC_W  = 33;

	localparam logic [14:0]      LEHMER_MULT = 15'd16807;
	localparam logic [31:0]      LEHMER_MOD  = 32'h7FFF_FFFF;
	localparam logic [GEN_W-1:0] SEED_RESET  = 31'd54301;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// one classified draw waiting for the modulo unit
	typedef struct packed {
		logic [GEN_W-1:0]        raw;
		logic [COUNT_W-1:0]      count;
		logic signed [GEN_W-1:0] range_low;
		logic                    flag;
	} draw_t;

endpackage

### rtl/lrd_in_if.sv
// lrd_in_if: draw request channel (valid/ready plus range and threshold)
// depends on lrd_pkg
interface lrd_in_if import lrd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [GEN_W-1:0] range_low;
	logic signed [GEN_W-1:0] range_high;
	logic [GEN_W-1:0]        prob_threshold;

	modport source (output valid, range_low, range_high, prob_threshold, input ready);
	modport sink (input valid, range_low, range_high, prob_threshold, output ready);
endinterface

### rtl/lrd_out_if.sv
// lrd_out_if: draw result channel (valid/ready plus raw, discrete and flag)
// depends on lrd_pkg
interface lrd_out_if import lrd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [GEN_W-1:0]         raw_value;
	logic signed [DISC_W-1:0] discrete_value;
	logic                     bernoulli_flag;

	modport source (output valid, raw_value, discrete_value, bernoulli_flag, input ready);
	modport sink (input valid, raw_value, discrete_value, bernoulli_flag, output ready);
endinterface

### rtl/lrd_cfg_if.sv
// lrd_cfg_if: seed write channel (valid/ready plus write data)
// depends on lrd_pkg
interface lrd_cfg_if import lrd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [GEN_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### rtl/lrd_front.sv
// lrd_front: generator state, seed load, draw request intake and classification
// depends on lrd_pkg, lrd_in_if, lrd_cfg_if
module lrd_front import lrd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	lrd_in_if.sink   in_ch,
	lrd_cfg_if.sink  cfg_ch,
	output logic     push_valid,
	input  logic     push_ready,
	output draw_t    push_data
);

	logic [GEN_W-1:0]        gen_q;
	logic [31:0]             prod_lo;
	logic [31:0]             prod_hi;
	logic [31:0]             fold;
	logic [GEN_W-1:0]        gen_next;
	logic                    accept;

	logic                    valid_s1;
	logic [GEN_W-1:0]        raw_s1;
	logic signed [GEN_W-1:0] low_s1;
	logic signed [GEN_W-1:0] high_s1;
	logic [GEN_W-1:0]        thr_s1;

	logic signed [COUNT_W-1:0] diff;
	logic [COUNT_W-1:0]        mag;

	// state * 16807 mod 2^31-1 by split halves and one fold
	always_comb begin
		prod_lo = 32'(LEHMER_MULT) * {16'd0, gen_q[15:0]};
		prod_hi = 32'(LEHMER_MULT) * {17'd0, gen_q[30:16]};
		fold    = prod_lo + {1'b0, prod_hi[14:0], 16'd0} + {15'd0, prod_hi[31:15]};
		if (fold > LEHMER_MOD) begin
			fold = fold - LEHMER_MOD;
		end
		gen_next = fold[GEN_W-1:0];
	end

	assign in_ch.ready  = !valid_s1 || push_ready;
	assign accept       = in_ch.valid && in_ch.ready;
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q    <= SEED_RESET;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_ch.valid) begin
				gen_q <= cfg_ch.data;
			end else if (accept) begin
				gen_q <= gen_next;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (push_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_s1  <= gen_next;
			low_s1  <= in_ch.range_low;
			high_s1 <= in_ch.range_high;
			thr_s1  <= in_ch.prob_threshold;
		end
	end

	// count = |high - low| + 1, at most 2^31
	always_comb begin
		diff = COUNT_W'(high_s1) - COUNT_W'(low_s1);
		mag  = diff[COUNT_W-1] ? COUNT_W'(-diff) : COUNT_W'(diff);
		push_data.raw       = raw_s1;
		push_data.count     = mag + COUNT_W'(1);
		push_data.range_low = low_s1;
		push_data.flag      = (raw_s1 <= thr_s1);
	end

	assign push_valid = valid_s1;

endmodule

### rtl/lrd_queue.sv
// lrd_queue: short fifo of classified draws between front and modulo unit
// depends on lrd_pkg
module lrd_queue import lrd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  draw_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output draw_t pop_data
);

	draw_t             entries [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = entries[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/lrd_back.sv
// lrd_back: restoring radix-2 modulo of raw by count, then result register
// depends on lrd_pkg, lrd_out_if
module lrd_back import lrd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pop_valid,
	output logic     pop_ready,
	input  draw_t    pop_data,
	lrd_out_if.source out_ch
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;
	localparam int unsigned IDX_W  = $clog2(GEN_W);

	logic [1:0]         state_q;
	logic [IDX_W-1:0]   idx_q;
	draw_t              work_q;
	logic [GEN_W-1:0]   rem_q;
	logic [COUNT_W-1:0] trial;
	logic               out_valid_q;
	logic               out_free;
	logic               out_load;

	assign pop_ready = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || out_ch.ready;
	assign out_load  = (state_q == ST_DONE) && out_free;
	assign trial     = {rem_q, work_q.raw[idx_q]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (idx_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				work_q <= pop_data;
				rem_q  <= '0;
				idx_q  <= IDX_W'(GEN_W - 1);
			end
			ST_DIV: begin
				// remainder stays below count, so it fits the raw width
				if (trial >= work_q.count) begin
					rem_q <= GEN_W'(trial - work_q.count);
				end else begin
					rem_q <= trial[GEN_W-1:0];
				end
				idx_q <= idx_q - 1'b1;
			end
			ST_DONE: begin
				if (out_free) begin
					out_ch.raw_value      <= work_q.raw;
					out_ch.discrete_value <= DISC_W'(work_q.range_low)
						+ $signed({{(DISC_W - GEN_W){1'b0}}, rem_q});
					out_ch.bernoulli_flag <= work_q.flag;
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign out_ch.valid = out_valid_q;

endmodule

### rtl/lehmer_rng_range_draw.sv
// lehmer_rng_range_draw: park-miller generator with range and bernoulli draws
// throughput is set by the 31-step restoring modulo unit in lrd_back, which works
// on one draw at a time and takes the next only once its result is registered
// the front takes requests ahead through a 2-entry queue while the unit works
// reset (async, active low) loads the generator with seed 54301 and empties all stages
// depends on lrd_pkg, the three channel interfaces, lrd_front, lrd_queue, lrd_back
module lehmer_rng_range_draw import lrd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lrd_in_if.sink    in_ch,
	lrd_out_if.source out_ch,
	lrd_cfg_if.sink   cfg_ch
);

	logic  push_valid;
	logic  push_ready;
	draw_t push_data;
	logic  pop_valid;
	logic  pop_ready;
	draw_t pop_data;

	lrd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.cfg_ch     (cfg_ch),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	lrd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	lrd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_ch    (out_ch)
	);

endmodule

### dv/lehmer_rng_range_draw_tb.sv
// lehmer_rng_range_draw_tb: self-checking bench for the lehmer range draw block
// drives draw requests and seed writes, predicts raw, discrete and flag per request
// depends on lrd_pkg, lrd_in_if, lrd_out_if, lrd_cfg_if and lehmer_rng_range_draw
module lehmer_rng_range_draw_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lrd_pkg::*;

	localparam logic [31:0]             PM_MULT       = 32'd16807;
	localparam logic [31:0]             PM_MOD        = 32'h7FFF_FFFF;
	localparam logic [GEN_W-1:0]        SEED_AT_RESET = 31'd54301;
	localparam logic signed [GEN_W-1:0] RANGE_MIN     = 31'h4000_0000;
	localparam logic signed [GEN_W-1:0] RANGE_MAX     = 31'h3FFF_FFFF;
	localparam logic [GEN_W-1:0]        THR_MAX       = 31'h7FFF_FFFF;
	localparam int unsigned             CYCLE_LIMIT   = 500_000;
	localparam int unsigned             HOLD_CYCLES   = 400;
	localparam int unsigned             DRAIN_CYCLES  = 60;
	localparam int unsigned             GAP_PERCENT   = 12;
	localparam int unsigned             MAX_REPORTS   = 10;

	typedef struct packed {
		logic signed [GEN_W-1:0] range_low;
		logic signed [GEN_W-1:0] range_high;
		logic [GEN_W-1:0]        prob_threshold;
	} draw_req_t;

	typedef struct packed {
		logic [GEN_W-1:0]         raw_value;
		logic signed [DISC_W-1:0] discrete_value;
		logic                     bernoulli_flag;
	} draw_res_t;

	logic clk;
	logic arst_n;

	lrd_in_if  draw_in ();
	lrd_out_if draw_out ();
	lrd_cfg_if seed_cfg ();

	lehmer_rng_range_draw DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (draw_in),
		.out_ch (draw_out),
		.cfg_ch (seed_cfg)
	);

	draw_req_t        pending_draws[$];
	draw_res_t        expected_draws[$];
	logic [GEN_W-1:0] gen_state;
	logic [GEN_W-1:0] preview_state;
	bit               gaps_on;
	bit               hold_start;
	bit               hold_done = 0;
	int unsigned      hold_left = 0;
	int unsigned      cycle_count = 0;
	int unsigned      fail_count = 0;
	int unsigned      draws_checked = 0;
	int unsigned      seed_loads = 0;

	// park-miller step: 16-bit low and 15-bit high halves, fold the high part, one conditional subtract
	function automatic logic [GEN_W-1:0] lehmer_advance(input logic [GEN_W-1:0] s);
		logic [31:0] lo_prod;
		logic [31:0] hi_prod;
		lo_prod = PM_MULT * 32'(s[15:0]);
		hi_prod = PM_MULT * 32'(s[30:16]);
		lo_prod = lo_prod + {hi_prod[14:0], 16'h0000} + (hi_prod >> 15);
		if (lo_prod > PM_MOD) begin
			lo_prod = lo_prod - PM_MOD;
		end
		return lo_prod[GEN_W-1:0];
	endfunction

	function automatic draw_res_t draw_outcome(input draw_req_t req, input logic [GEN_W-1:0] raw);
		draw_res_t res;
		longint    lo_end;
		longint    hi_end;
		longint    span;
		longint    sum;
		lo_end = req.range_low;
		hi_end = req.range_high;
		span = hi_end - lo_end;
		if (span < 0) begin
			span = -span;
		end
		// reversed ranges still count upward from the low end
		sum = lo_end + (longint'(raw) % (span + 1));
		res.raw_value = raw;
		res.discrete_value = sum[DISC_W-1:0];
		res.bernoulli_flag = (raw <= req.prob_threshold);
		return res;
	endfunction

	function automatic draw_req_t random_draw();
		draw_req_t   req;
		int unsigned pick;
		pick = $urandom_range(99);
		req.range_low = 31'($urandom);
		if (pick < 45) begin
			req.range_high = req.range_low + 31'($urandom_range(64));
		end else if (pick < 60) begin
			req.range_high = req.range_low - 31'($urandom_range(64));
		end else if (pick < 70) begin
			req.range_high = req.range_low;
		end else begin
			req.range_high = 31'($urandom);
		end
		pick = $urandom_range(99);
		if (pick < 10) begin
			req.prob_threshold = '0;
		end else if (pick < 20) begin
			req.prob_threshold = THR_MAX;
		end else begin
			req.prob_threshold = 31'($urandom);
		end
		return req;
	endfunction

	function automatic void queue_draw(input logic signed [GEN_W-1:0] lo,
		input logic signed [GEN_W-1:0] hi, input logic [GEN_W-1:0] thr);
		draw_req_t req;
		req.range_low = lo;
		req.range_high = hi;
		req.prob_threshold = thr;
		pending_draws.push_back(req);
		preview_state = lehmer_advance(preview_state);
	endfunction

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_draws.size() != 0 || draw_in.valid || expected_draws.size() != 0);
	endtask

	task automatic load_seed(input logic [GEN_W-1:0] seed);
		@(posedge clk);
		seed_cfg.valid <= 1'b1;
		seed_cfg.data <= seed;
		do @(posedge clk);
		while (!seed_cfg.ready);
		seed_cfg.valid <= 1'b0;
		gen_state = seed;
		preview_state = seed;
		seed_loads++;
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// request driver: predicts on acceptance, then offers the next pending request
	always @(posedge clk) begin : draw_driver
		draw_req_t req;
		draw_req_t nxt;
		if (arst_n) begin
			if (draw_in.valid && draw_in.ready) begin
				req.range_low = draw_in.range_low;
				req.range_high = draw_in.range_high;
				req.prob_threshold = draw_in.prob_threshold;
				gen_state = lehmer_advance(gen_state);
				expected_draws.push_back(draw_outcome(req, gen_state));
			end
			if (!draw_in.valid || draw_in.ready) begin
				if (pending_draws.size() != 0 && !(gaps_on && $urandom_range(99) < GAP_PERCENT)) begin
					nxt = pending_draws.pop_front();
					draw_in.valid <= 1'b1;
					draw_in.range_low <= nxt.range_low;
					draw_in.range_high <= nxt.range_high;
					draw_in.prob_threshold <= nxt.prob_threshold;
				end else begin
					draw_in.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off so the queue fills and the input stalls
	always @(posedge clk) begin
		if (hold_start && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin : result_monitor
		draw_res_t want;
		if (arst_n) begin
			if (draw_out.valid && draw_out.ready) begin
				if (expected_draws.size() == 0) begin
					if (fail_count < MAX_REPORTS) begin
						$display("unexpected result: raw %0d disc %0d flag %0b",
							draw_out.raw_value, $signed(draw_out.discrete_value),
							draw_out.bernoulli_flag);
					end
					fail_count++;
				end else begin
					want = expected_draws.pop_front();
					if (draw_out.raw_value !== want.raw_value
						|| draw_out.discrete_value !== want.discrete_value
						|| draw_out.bernoulli_flag !== want.bernoulli_flag) begin
						if (fail_count < MAX_REPORTS) begin
							$display("draw %0d: raw %0d/%0d disc %0d/%0d flag %0b/%0b (exp/got)",
								draws_checked, want.raw_value, draw_out.raw_value,
								$signed(want.discrete_value), $signed(draw_out.discrete_value),
								want.bernoulli_flag, draw_out.bernoulli_flag);
						end
						fail_count++;
					end
					draws_checked++;
				end
			end
			if (hold_left != 0) begin
				draw_out.ready <= 1'b0;
			end else begin
				draw_out.ready <= !(gaps_on && $urandom_range(99) < GAP_PERCENT);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				expected_draws.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		draw_in.valid = 1'b0;
		draw_in.range_low = '0;
		draw_in.range_high = '0;
		draw_in.prob_threshold = '0;
		draw_out.ready = 1'b0;
		seed_cfg.valid = 1'b0;
		seed_cfg.data = '0;
		gaps_on = 1'b1;
		hold_start = 1'b0;
		gen_state = SEED_AT_RESET;
		preview_state = SEED_AT_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset seed: full, reversed full, single-value and small ranges, threshold at and just below the raw value
		queue_draw(RANGE_MIN, RANGE_MAX, '0);
		queue_draw(RANGE_MAX, RANGE_MIN, THR_MAX);
		queue_draw(RANGE_MIN, RANGE_MIN, lehmer_advance(preview_state));
		queue_draw(RANGE_MAX, RANGE_MAX, lehmer_advance(preview_state) - 31'd1);
		queue_draw(31'sd5, -31'sd3, 31'h5555_5555);
		queue_draw(-31'sd3, 31'sd5, 31'h2AAA_AAAA);
		queue_draw(31'sd0, 31'sd0, '0);
		queue_draw(-31'sd1, 31'sd0, 31'h4000_0000);
		queue_draw(31'sd0, 31'sd1, 31'h3FFF_FFFF);
		queue_draw(-31'sd10, 31'sd10, THR_MAX);

		// zero seed sticks at zero, all-ones seed sticks at all ones
		wait_idle();
		load_seed('0);
		queue_draw(31'sd7, 31'sd20, '0);
		queue_draw(RANGE_MIN, RANGE_MAX, '0);
		queue_draw(-31'sd5, -31'sd9, THR_MAX);
		wait_idle();
		load_seed(31'h7FFF_FFFF);
		queue_draw(RANGE_MIN, RANGE_MAX, THR_MAX);
		queue_draw(31'sd0, 31'sd0, 31'h7FFF_FFFE);
		queue_draw(-31'sd100, 31'sd100, '0);
		wait_idle();
		load_seed(31'd1);
		queue_draw(31'sd0, 31'sd99, 31'd16807);
		queue_draw(RANGE_MAX, RANGE_MIN, 31'd16806);
		queue_draw(-31'sd50, 31'sd50, THR_MAX);
		wait_idle();
		load_seed(31'd2147483646);
		queue_draw(RANGE_MIN, RANGE_MAX, 31'h7FFF_FFFE);
		queue_draw(31'sd1, -31'sd1, '0);
		queue_draw(RANGE_MIN, RANGE_MIN + 31'sd1, 31'h0000_FFFF);

		for (int ph = 0; ph < 4; ph++) begin
			wait_idle();
			load_seed(31'($urandom_range(2147483646, 1)));
			// second phase runs without any gaps on either side
			gaps_on = (ph != 1);
			repeat (275) pending_draws.push_back(random_draw());
			if (ph == 0) begin
				hold_start = 1'b1;
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("checked %0d draws across %0d seed loads plus the reset seed", draws_checked,
			seed_loads);
		$display("zero and all-ones seeds, full, reversed and single-value ranges, hold-off");
		if (fail_count == 0 && expected_draws.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d failures, %0d results never arrived", fail_count,
				expected_draws.size());
			$display("Verification failed");
		end
		$finish;
	end

endmodule
